[src/crcfp_pkg.sv]
package crcfp_pkg;

  localparam int unsigned MAX_PAYLOAD = 256;
  localparam int unsigned POS_W       = 17;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // frame positions of the fixed fields; the first payload byte sits at POS_PAYLOAD
  localparam logic [POS_W-1:0] POS_HDR2     = 17'd1;
  localparam logic [POS_W-1:0] POS_CMD      = 17'd2;
  localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd3;
  localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd4;
  localparam logic [POS_W-1:0] POS_PAYLOAD  = 17'd5;

  localparam logic [15:0] CRC_MSB          = 16'h8000;
  localparam logic [15:0] CRC_INIT         = 16'h0000;
  localparam logic [15:0] CRC_GEN_RESET    = 16'h1305;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;
  localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_ONE  = 3'd0,
    REG_HEADER_TWO  = 3'd1,
    REG_TRAILER_ONE = 3'd2,
    REG_TRAILER_TWO = 3'd3,
    REG_TIMEOUT     = 3'd4,
    REG_CRC_GEN     = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_IN_FRAME    = 3'd1,
    ST_OK          = 3'd2,
    ST_HEADER_BAD  = 3'd3,
    ST_TRAILER_BAD = 3'd4,
    ST_CRC_BAD     = 3'd5,
    ST_TOO_LONG    = 3'd6,
    ST_TIMEOUT     = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0]  header_one;
    logic [7:0]  header_two;
    logic [7:0]  trailer_one;
    logic [7:0]  trailer_two;
    logic [15:0] timeout_ticks;
    logic [15:0] crc_gen;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  frame_cmd;
    logic [15:0] frame_len;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        payload_valid;
  } result_t;

endpackage

[src/crcfp_crc.sv]
module crcfp_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  input  logic [15:0] poly,
  output logic [15:0] crc_out
);

  // one byte, MSB first, eight shift steps
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & crcfp_pkg::CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

[src/crcfp_core.sv]
module crcfp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 req_type,
  input  logic [7:0]           rx_byte,
  input  crcfp_pkg::cfg_t      cfg,
  output crcfp_pkg::result_t   res
);

  logic [crcfp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                        in_frame_r, in_frame_nxt;
  logic [7:0]                  cmd_r, cmd_nxt;
  logic [15:0]                 len_r, len_nxt;
  logic [15:0]                 crc_r, crc_nxt;
  logic [7:0]                  crc_lo_r, crc_lo_nxt;
  logic [15:0]                 ticks_r, ticks_nxt;

  logic [15:0]                 crc_fed;
  logic [crcfp_pkg::POS_W-1:0] tail;
  logic [crcfp_pkg::POS_W-1:0] pay_off;
  logic                        advance;

  crcfp_crc u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .poly    (cfg.crc_gen),
    .crc_out (crc_fed)
  );

  assign tail    = crcfp_pkg::POS_PAYLOAD + {1'b0, len_r};
  assign pay_off = pos_r - crcfp_pkg::POS_PAYLOAD;

  always_comb begin
    pos_nxt      = pos_r;
    in_frame_nxt = in_frame_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    ticks_nxt    = ticks_r;
    advance      = 1'b0;
    res          = '0;
    res.status   = crcfp_pkg::ST_IN_FRAME;

    if (req_type) begin
      if (!in_frame_r) begin
        res.status = crcfp_pkg::ST_IDLE;
      end else begin
        if (ticks_r != crcfp_pkg::TICKS_MAX) begin
          ticks_nxt = ticks_r + 16'd1;
        end
        if (ticks_nxt > cfg.timeout_ticks) begin
          res.status   = crcfp_pkg::ST_TIMEOUT;
          in_frame_nxt = 1'b0;
          pos_nxt      = '0;
        end
      end
    end else if (!in_frame_r) begin
      if (rx_byte == cfg.header_one) begin
        in_frame_nxt = 1'b1;
        pos_nxt      = crcfp_pkg::POS_HDR2;
        cmd_nxt      = '0;
        len_nxt      = '0;
        crc_nxt      = crcfp_pkg::CRC_INIT;
        ticks_nxt    = '0;
      end else begin
        res.status = crcfp_pkg::ST_HEADER_BAD;
        pos_nxt    = '0;
      end
    end else begin
      advance = 1'b1;
      priority if (pos_r == crcfp_pkg::POS_HDR2) begin
        if (rx_byte != cfg.header_two) begin
          res.status = crcfp_pkg::ST_HEADER_BAD;
          advance    = 1'b0;
        end
      end else if (pos_r == crcfp_pkg::POS_CMD) begin
        cmd_nxt = rx_byte;
        crc_nxt = crc_fed;
      end else if (pos_r == crcfp_pkg::POS_LEN_LO) begin
        len_nxt = {8'h00, rx_byte};
        crc_nxt = crc_fed;
      end else if (pos_r == crcfp_pkg::POS_LEN_HI) begin
        len_nxt = {rx_byte, len_r[7:0]};
        crc_nxt = crc_fed;
        if (32'(len_nxt) > crcfp_pkg::MAX_PAYLOAD) begin
          res.status = crcfp_pkg::ST_TOO_LONG;
          advance    = 1'b0;
        end
      end else if (pos_r < tail) begin
        crc_nxt           = crc_fed;
        res.payload_byte  = rx_byte;
        res.payload_index = pay_off[7:0];
        res.payload_valid = 1'b1;
      end else if (pos_r == tail) begin
        if (rx_byte != cfg.trailer_one) begin
          res.status = crcfp_pkg::ST_TRAILER_BAD;
          advance    = 1'b0;
        end
      end else if (pos_r == tail + 17'd1) begin
        if (rx_byte != cfg.trailer_two) begin
          res.status = crcfp_pkg::ST_TRAILER_BAD;
          advance    = 1'b0;
        end
      end else if (pos_r == tail + 17'd2) begin
        crc_lo_nxt = rx_byte;
      end else begin
        res.status = ({rx_byte, crc_lo_r} == crc_r) ? crcfp_pkg::ST_OK
                                                    : crcfp_pkg::ST_CRC_BAD;
        advance    = 1'b0;
      end
      if (advance) begin
        pos_nxt = pos_r + 17'd1;
      end else begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
      end
    end

    res.frame_cmd = cmd_nxt;
    res.frame_len = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      in_frame_r <= 1'b0;
      cmd_r      <= '0;
      len_r      <= '0;
      crc_r      <= crcfp_pkg::CRC_INIT;
      crc_lo_r   <= '0;
      ticks_r    <= '0;
    end else if (step) begin
      pos_r      <= pos_nxt;
      in_frame_r <= in_frame_nxt;
      cmd_r      <= cmd_nxt;
      len_r      <= len_nxt;
      crc_r      <= crc_nxt;
      crc_lo_r   <= crc_lo_nxt;
      ticks_r    <= ticks_nxt;
    end
  end

endmodule

[src/crc16_framed_packet_parser.sv]
// Throughput: one beat per cycle while out_ready does not stall the result register;
// an input register and a result register decouple the two sides, the frame state
// and byte-wide CRC sit between them.
// Reset (rst_n low, synchronous): both stages empty, parser hunting for a header,
// config registers back to their defaults.
module crc16_framed_packet_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic [7:0]                       out_frame_cmd,
  output logic [15:0]                      out_frame_len,
  output logic [7:0]                       out_payload_byte,
  output logic [7:0]                       out_payload_index,
  output logic                             out_payload_valid,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crcfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crcfp_pkg::CFG_DATA_W-1:0] cfg_data
);

  crcfp_pkg::cfg_t    cfg_r;
  crcfp_pkg::result_t res;
  crcfp_pkg::result_t res_r;

  logic       s1_valid_r;
  logic       s1_type_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic       step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_one    <= '0;
      cfg_r.header_two    <= '0;
      cfg_r.trailer_one   <= '0;
      cfg_r.trailer_two   <= '0;
      cfg_r.timeout_ticks <= crcfp_pkg::TIMEOUT_RESET;
      cfg_r.crc_gen       <= crcfp_pkg::CRC_GEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        crcfp_pkg::REG_HEADER_ONE:  cfg_r.header_one    <= cfg_data[7:0];
        crcfp_pkg::REG_HEADER_TWO:  cfg_r.header_two    <= cfg_data[7:0];
        crcfp_pkg::REG_TRAILER_ONE: cfg_r.trailer_one   <= cfg_data[7:0];
        crcfp_pkg::REG_TRAILER_TWO: cfg_r.trailer_two   <= cfg_data[7:0];
        crcfp_pkg::REG_TIMEOUT:     cfg_r.timeout_ticks <= cfg_data;
        crcfp_pkg::REG_CRC_GEN:     cfg_r.crc_gen       <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage moves on whenever the result register is free or draining
  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_type_r <= in_req_type;
      s1_byte_r <= in_rx_byte;
    end
  end

  crcfp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .req_type (s1_type_r),
    .rx_byte  (s1_byte_r),
    .cfg      (cfg_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= step || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_frame_cmd     = res_r.frame_cmd;
  assign out_frame_len     = res_r.frame_len;
  assign out_payload_byte  = res_r.payload_byte;
  assign out_payload_index = res_r.payload_index;
  assign out_payload_valid = res_r.payload_valid;

endmodule

[src/crcfp_checker.sv]
module crcfp_props (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_req_type,
  input logic [7:0]                       in_rx_byte,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [2:0]                       out_status,
  input logic [7:0]                       out_frame_cmd,
  input logic [15:0]                      out_frame_len,
  input logic [7:0]                       out_payload_byte,
  input logic [7:0]                       out_payload_index,
  input logic                             out_payload_valid,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [crcfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [crcfp_pkg::CFG_DATA_W-1:0] cfg_data
);

  // result beat held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_frame_len) && $stable(out_payload_byte))
    else $error("result beat changed while stalled");

  // payload bytes only ever come out mid-frame
  a_pay_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_status == crcfp_pkg::ST_IN_FRAME)
    else $error("payload beat with non in-frame status");

  a_pay_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> {8'h00, out_payload_index} < out_frame_len)
    else $error("payload index beyond frame length");

  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == crcfp_pkg::ST_OK || out_status == crcfp_pkg::ST_CRC_BAD)
      |-> 32'(out_frame_len) <= crcfp_pkg::MAX_PAYLOAD)
    else $error("completed frame longer than allowed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind crc16_framed_packet_parser crcfp_props u_crcfp_props (.*);
